// ----- src/mma_pkg.sv -----
// ----------------------------------------------------------------------------
// mma_pkg
// shared constants, operation codes and sequencer states of the modulation
// matrix accumulator
// ----------------------------------------------------------------------------
package mma_pkg;

    // number format: unsigned Q1.16, 65536 is 1.0
    localparam int FRAC_BITS    = 16;
    localparam int VAL_BITS     = 17;
    localparam int SLOT_BITS    = 6;
    localparam int MODE_BITS    = 4;

    // defaults of the top level parameters
    localparam int TARGETS_DEF  = 64;
    localparam int ACC_BITS_DEF = 24;

    // multiplier digit, bits of the second operand consumed per cycle
    localparam int DIGIT_BITS   = 8;

    // stream widths, fields packed from bit 0 up, padded to whole bytes
    localparam int IN_TDATA_BITS  = 80;
    localparam int OUT_TDATA_BITS = 24;

    // route operation codes
    localparam logic [MODE_BITS-1:0] MODE_OFF    = 4'd0;
    localparam logic [MODE_BITS-1:0] MODE_MULABS = 4'd1;
    localparam logic [MODE_BITS-1:0] MODE_MULREL = 4'd2;
    localparam logic [MODE_BITS-1:0] MODE_MULSTK = 4'd3;
    localparam logic [MODE_BITS-1:0] MODE_ADDABS = 4'd4;
    localparam logic [MODE_BITS-1:0] MODE_ADDREL = 4'd5;
    localparam logic [MODE_BITS-1:0] MODE_ADDSTK = 4'd6;
    localparam logic [MODE_BITS-1:0] MODE_ABABS  = 4'd7;
    localparam logic [MODE_BITS-1:0] MODE_ABREL  = 4'd8;
    localparam logic [MODE_BITS-1:0] MODE_ABSTK  = 4'd9;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_MUL,
        ST_ROUND,
        ST_AMT,
        ST_OPS,
        ST_RULE,
        ST_DONE
    } t_state;

endpackage

// ----- src/mma_ram.sv -----
// ----------------------------------------------------------------------------
// mma_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module mma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ----- src/modulation_matrix_accumulator_top.sv -----
// ----------------------------------------------------------------------------
// modulation_matrix_accumulator_top
// Each request is one modulation route of the current sample frame. The block
// forms the route amount low + (high - low) * source, applies the selected
// multiply, add or bipolar-add rule to the target's accumulator (seeded from
// the base value on the first touch in a frame) and returns the accumulated
// value clamped to zero..one. All products go through one shared
// magnitude multiplier that takes 8 bits of its second operand per cycle.
// Requests whose mode is off or unknown, or whose slot is out of range, skip
// the multiplier; the plain add modes use it once and the others twice. The
// input is not ready while a request is in progress. Accumulators live in
// a ram with registered read; the touched marks are flip-flops that a frame
// start clears at once, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module modulation_matrix_accumulator_top #(
    parameter int TARGETS  = mma_pkg::TARGETS_DEF,
    parameter int ACC_BITS = mma_pkg::ACC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // mode, target_index, target_base, source_level, low_bound, high_bound
    input  logic [mma_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
    // frame_start
    input  logic [0:0]                         s_axis_tuser,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // out_target, out_value
    output logic [mma_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
    // applied
    output logic [0:0]                         m_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready
);

    import mma_pkg::*;

    localparam int MAX_SLOTS = 1 << SLOT_BITS;
    localparam int SLOTS     = (TARGETS < MAX_SLOTS) ? TARGETS : MAX_SLOTS;
    localparam int IW        = $clog2(SLOTS);
    localparam int XW        = ACC_BITS + 3;
    localparam int MW        = XW;
    localparam int NDIG      = (MW + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int NB        = NDIG * DIGIT_BITS;
    localparam int PW        = MW + NB;
    localparam int CW        = $clog2(NDIG + 1);

    localparam logic signed [XW-1:0] ONE_X     = XW'(1 << FRAC_BITS);
    localparam logic signed [XW-1:0] HALF_X    = ONE_X >>> 1;
    localparam logic signed [XW-1:0] ACC_MAX_X = XW'((64'sd1 <<< (ACC_BITS - 1)) - 64'sd1);
    localparam logic signed [XW-1:0] ACC_MIN_X = ~ACC_MAX_X;
    localparam logic [PW-1:0]        Q_MAX     = PW'((64'd1 << (ACC_BITS - 1)) - 64'd1);
    localparam logic [CW-1:0]        LAST_DIG  = CW'(NDIG - 1);

    function automatic logic signed [ACC_BITS-1:0] f_sat(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] t;
        t = v;
        if (v > ACC_MAX_X) begin
            t = ACC_MAX_X;
        end else if (v < ACC_MIN_X) begin
            t = ACC_MIN_X;
        end
        return t[ACC_BITS-1:0];
    endfunction

    function automatic logic signed [XW-1:0] f_ext_u(input logic [VAL_BITS-1:0] v);
        return $signed({{(XW - VAL_BITS){1'b0}}, v});
    endfunction

    function automatic logic signed [XW-1:0] f_ext_a(input logic signed [ACC_BITS-1:0] v);
        return $signed({{(XW - ACC_BITS){v[ACC_BITS-1]}}, v});
    endfunction

    function automatic logic [XW-1:0] f_mag(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] t;
        t = v[XW-1] ? -v : v;
        return $unsigned(t);
    endfunction

    // ---------------- registers ----------------
    t_state                       r_state, n_state;
    logic [MODE_BITS-1:0]         r_mode;
    logic [SLOT_BITS-1:0]         r_slot;
    logic [VAL_BITS-1:0]          r_base, r_src, r_lo, r_hi;
    logic [SLOTS-1:0]             r_touched;
    logic signed [ACC_BITS-1:0]   r_acc, r_m, r_q;
    logic                         r_phase;
    logic                         r_neg;
    logic [MW-1:0]                r_mag_a;
    logic [PW-1:0]                r_prod;
    logic [CW-1:0]                r_cnt;
    logic                         r_ovalid;
    logic [SLOT_BITS-1:0]         r_otarget;
    logic [VAL_BITS-1:0]          r_ovalue;
    logic                         r_oapplied;

    // ---------------- datapath signals ----------------
    logic [IW-1:0]                w_idx;
    logic                         w_in_range, w_active, w_hit, w_out_free;
    logic [ACC_BITS-1:0]          w_ram_q;
    logic signed [XW-1:0]         w_a, w_m, w_b, w_q;
    logic signed [XW-1:0]         w_one_b, w_one_a, w_w_b, w_w_a, w_m_half;
    logic signed [XW-1:0]         w_op_a, w_op_b;
    logic                         w_start;
    logic [DIGIT_BITS-1:0]        w_digit;
    logic [MW+DIGIT_BITS-1:0]     w_psum;
    logic [PW-1:0]                w_qfull, w_qr;
    logic                         w_sticky;
    logic signed [ACC_BITS-1:0]   w_round;
    logic [VAL_BITS-1:0]          w_clamp;
    logic signed [XW-1:0]         w_acc_x;

    assign w_idx      = r_slot[IW-1:0];
    assign w_in_range = (32'(r_slot) < TARGETS);
    assign w_active   = w_in_range && (r_mode inside {[MODE_MULABS:MODE_ABSTK]});
    assign w_hit      = w_in_range && r_touched[w_idx];
    assign w_out_free = !r_ovalid || m_axis_tready;

    assign w_a        = f_ext_a(r_acc);
    assign w_m        = f_ext_a(r_m);
    assign w_b        = f_ext_u(r_base);
    assign w_q        = f_ext_a(r_q);
    assign w_one_b    = ONE_X - w_b;
    assign w_one_a    = ONE_X - w_a;
    assign w_w_b      = ONE_X - (f_mag(HALF_X - w_b) <<< 1);
    assign w_w_a      = ONE_X - (f_mag(HALF_X - w_a) <<< 1);
    assign w_m_half   = w_m - HALF_X;

    // one digit of the shared multiplier
    assign w_digit = r_prod[DIGIT_BITS-1:0];
    assign w_psum  = {{DIGIT_BITS{1'b0}}, r_prod[PW-1:NB]} + r_mag_a * w_digit;

    // floor toward minus infinity, then saturate
    assign w_qfull  = r_prod >> FRAC_BITS;
    assign w_sticky = |r_prod[FRAC_BITS-1:0];
    assign w_qr     = w_qfull + PW'(r_neg & w_sticky);
    always_comb begin
        if (w_qr > Q_MAX) begin
            w_round = r_neg ? ACC_MIN_X[ACC_BITS-1:0] : ACC_MAX_X[ACC_BITS-1:0];
        end else if (r_neg) begin
            w_round = -$signed(w_qr[ACC_BITS-1:0]);
        end else begin
            w_round = $signed(w_qr[ACC_BITS-1:0]);
        end
    end

    assign w_acc_x = f_ext_a(r_acc);
    always_comb begin
        if (w_acc_x < 0) begin
            w_clamp = '0;
        end else if (w_acc_x > ONE_X) begin
            w_clamp = ONE_X[VAL_BITS-1:0];
        end else begin
            w_clamp = w_acc_x[VAL_BITS-1:0];
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_start = 1'b0;
        w_op_a  = w_a;
        w_op_b  = w_m;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                w_op_a = f_ext_u(r_hi) - f_ext_u(r_lo);
                w_op_b = f_ext_u(r_src);
                if (w_active) begin
                    w_start = 1'b1;
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_MUL: begin
                if (r_cnt == LAST_DIG) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                n_state = r_phase ? ST_RULE : ST_AMT;
            end
            ST_AMT: begin
                n_state = ST_OPS;
            end
            ST_OPS: begin
                w_start = 1'b1;
                n_state = ST_MUL;
                case (r_mode)
                    MODE_ADDABS, MODE_ABABS: begin
                        w_start = 1'b0;
                        n_state = ST_DONE;
                    end
                    MODE_MULABS: begin
                        w_op_a = w_a;
                        w_op_b = w_m;
                    end
                    MODE_MULREL: begin
                        w_op_a = w_m;
                        w_op_b = w_one_b;
                    end
                    MODE_MULSTK: begin
                        w_op_a = w_m;
                        w_op_b = w_one_a;
                    end
                    MODE_ADDREL: begin
                        w_op_a = w_one_b;
                        w_op_b = w_m;
                    end
                    MODE_ADDSTK: begin
                        w_op_a = w_one_a;
                        w_op_b = w_m;
                    end
                    MODE_ABREL: begin
                        w_op_a = w_w_b;
                        w_op_b = w_m_half;
                    end
                    default: begin
                        w_op_a = w_w_a;
                        w_op_b = w_m_half;
                    end
                endcase
            end
            ST_RULE: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);

    // ---------------- accumulator ram ----------------
    mma_ram #(
        .WIDTH (ACC_BITS),
        .DEPTH (SLOTS)
    ) u_acc_ram (
        .i_clk     (i_clk),
        .i_wr_en   ((r_state == ST_DONE) && w_out_free && w_active),
        .i_wr_addr (w_idx),
        .i_wr_data (r_acc),
        .i_rd_addr (w_idx),
        .o_rd_data (w_ram_q)
    );

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touched <= '0;
            r_ovalid  <= 1'b0;
            r_phase   <= 1'b0;
            r_cnt     <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready && s_axis_tuser[0]) begin
                r_touched <= '0;
            end
            if (w_start) begin
                r_cnt   <= '0;
                r_phase <= (r_state == ST_OPS);
            end else if (r_state == ST_MUL) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_ovalid <= 1'b1;
                if (w_active) begin
                    r_touched[w_idx] <= 1'b1;
                end
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_mode <= s_axis_tdata[3:0];
            r_slot <= s_axis_tdata[9:4];
            r_base <= s_axis_tdata[26:10];
            r_src  <= s_axis_tdata[43:27];
            r_lo   <= s_axis_tdata[60:44];
            r_hi   <= s_axis_tdata[77:61];
        end
        if (w_start) begin
            r_neg   <= w_op_a[XW-1] ^ w_op_b[XW-1];
            r_mag_a <= f_mag(w_op_a);
            r_prod  <= {{MW{1'b0}}, NB'(f_mag(w_op_b))};
        end else if (r_state == ST_MUL) begin
            r_prod <= {w_psum, r_prod[NB-1:DIGIT_BITS]};
        end
        if (r_state == ST_ROUND) begin
            r_q <= w_round;
        end
        case (r_state)
            ST_LOAD: begin
                // seed from the base on the first touch in this frame
                r_acc <= w_hit ? $signed(w_ram_q) : f_sat(w_b);
            end
            ST_AMT: begin
                r_m <= f_sat(f_ext_u(r_lo) + w_q);
            end
            ST_OPS: begin
                if (r_mode == MODE_ADDABS) begin
                    r_acc <= f_sat(w_a + w_m);
                end else if (r_mode == MODE_ABABS) begin
                    r_acc <= f_sat(w_a + w_m_half);
                end
            end
            ST_RULE: begin
                if (r_mode == MODE_MULABS) begin
                    r_acc <= r_q;
                end else if (r_mode == MODE_MULREL) begin
                    r_acc <= f_sat(w_b + w_q);
                end else begin
                    r_acc <= f_sat(w_a + w_q);
                end
            end
            default: begin
            end
        endcase
        if (r_state == ST_DONE && w_out_free) begin
            r_otarget  <= r_slot;
            r_ovalue   <= w_clamp;
            r_oapplied <= w_active;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_ovalue, r_otarget};
    assign m_axis_tuser  = r_oapplied;

endmodule
